FILE: rtl/usd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package usd_pkg;

   localparam int CP_WIDTH  = 31;
   localparam int LEN_WIDTH = 3;
   localparam int REM_WIDTH = 3;

   // Byte classification masks.
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_TAG     = 8'h80;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

   localparam logic [CP_WIDTH-1:0] MAX_CP_RESET = 31'h0010_FFFF;

   // Sequence lengths.
   localparam logic [LEN_WIDTH-1:0] LEN_1 = 3'd1;
   localparam logic [LEN_WIDTH-1:0] LEN_2 = 3'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_3 = 3'd3;
   localparam logic [LEN_WIDTH-1:0] LEN_4 = 3'd4;
   localparam logic [LEN_WIDTH-1:0] LEN_5 = 3'd5;
   localparam logic [LEN_WIDTH-1:0] LEN_6 = 3'd6;

   typedef struct packed {
      logic [REM_WIDTH-1:0] remaining;
      logic [CP_WIDTH-1:0]  value;
      logic [LEN_WIDTH-1:0] length;
   } usd_state_type;

   typedef struct packed {
      logic                 accepted;
      logic                 done_res;
      logic [CP_WIDTH-1:0]  code_point;
      logic [LEN_WIDTH-1:0] seq_length;
      logic                 overlong;
      logic                 above_bound;
   } usd_result_type;

endpackage

FILE: rtl/usd_step_logic.sv
// Combinational decode of one byte against the current decoder state.
module usd_step_logic (
   input  usd_pkg::usd_state_type  state_cur,
   input  logic                    restart,
   input  logic [7:0]              in_byte,
   input  logic [usd_pkg::CP_WIDTH-1:0] max_code_point,
   output usd_pkg::usd_state_type  state_nxt,
   output usd_pkg::usd_result_type result
);
   import usd_pkg::*;

   usd_state_type base;
   logic          ok;
   logic          done;
   logic          is_cont;
   logic          short_form;
   logic [5:0]    payload;

   assign is_cont = (in_byte & CONT_MASK) == CONT_TAG;
   assign payload = 6'(in_byte & PAYLOAD_MASK);

   always_comb begin
      base      = restart ? '0 : state_cur;
      state_nxt = base;
      ok        = 1'b0;
      done      = 1'b0;
      if (base.remaining != '0) begin
         if (is_cont) begin
            state_nxt.value     = {base.value[CP_WIDTH-7:0], payload};
            state_nxt.remaining = base.remaining - 3'd1;
            ok                  = 1'b1;
            done                = (base.remaining == 3'd1);
         end
      end else begin
         unique casez (in_byte)
            8'b0???????: begin
               state_nxt.value  = CP_WIDTH'(in_byte);
               state_nxt.length = LEN_1;
               ok               = 1'b1;
               done             = 1'b1;
            end
            8'b110?????: begin
               state_nxt.value     = CP_WIDTH'(in_byte[4:0]);
               state_nxt.length    = LEN_2;
               state_nxt.remaining = 3'd1;
               ok                  = 1'b1;
            end
            8'b1110????: begin
               state_nxt.value     = CP_WIDTH'(in_byte[3:0]);
               state_nxt.length    = LEN_3;
               state_nxt.remaining = 3'd2;
               ok                  = 1'b1;
            end
            8'b11110???: begin
               state_nxt.value     = CP_WIDTH'(in_byte[2:0]);
               state_nxt.length    = LEN_4;
               state_nxt.remaining = 3'd3;
               ok                  = 1'b1;
            end
            8'b111110??: begin
               state_nxt.value     = CP_WIDTH'(in_byte[1:0]);
               state_nxt.length    = LEN_5;
               state_nxt.remaining = 3'd4;
               ok                  = 1'b1;
            end
            8'b1111110?: begin
               state_nxt.value     = CP_WIDTH'(in_byte[0]);
               state_nxt.length    = LEN_6;
               state_nxt.remaining = 3'd5;
               ok                  = 1'b1;
            end
            default: begin
               // Stray continuation byte, 0xFE or 0xFF: state stays as it is.
               ok = 1'b0;
            end
         endcase
      end
   end

   // A value is overlong when its bits from the shorter form's limit upward are all zero.
   always_comb begin
      unique case (state_nxt.length)
         LEN_2:   short_form = state_nxt.value[CP_WIDTH-1:7]  == '0;
         LEN_3:   short_form = state_nxt.value[CP_WIDTH-1:11] == '0;
         LEN_4:   short_form = state_nxt.value[CP_WIDTH-1:16] == '0;
         LEN_5:   short_form = state_nxt.value[CP_WIDTH-1:21] == '0;
         LEN_6:   short_form = state_nxt.value[CP_WIDTH-1:26] == '0;
         default: short_form = 1'b0;
      endcase
   end

   assign result.accepted    = ok;
   assign result.done_res    = done;
   assign result.code_point  = state_nxt.value;
   assign result.seq_length  = state_nxt.length;
   assign result.overlong    = done && short_form;
   assign result.above_bound = done && (state_nxt.value > max_code_point);

endmodule

FILE: rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: input register, decode step and result register.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_stall     req_restart, req_in_byte
//   rsp_      out        rsp_valid / rsp_stall     accepted, done_res, code_point,
//                                                  seq_length, overlong, above_bound
//   csr_      in         csr_wr_en                 csr_wr_data (max_code_point)
//
// One beat is taken on req_ in every cycle as long as the result side keeps up.
// A taken beat first sits in the input register; the decode step writes the result
// register and the state once the result register can load, and the beat then
// shows on rsp_.
// Reset clears the valid flags and the decoder state, and loads the bound
// register with 0x10FFFF. When rsp_stall holds the result register, the input
// register still fills once, and req_stall rises only while both are full.
module utf8_stream_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_done_res,
   output logic [usd_pkg::CP_WIDTH-1:0]  rsp_code_point,
   output logic [usd_pkg::LEN_WIDTH-1:0] rsp_seq_length,
   output logic                          rsp_overlong,
   output logic                          rsp_above_bound,
   input  logic                          csr_wr_en,
   input  logic [usd_pkg::CP_WIDTH-1:0]  csr_wr_data
);
   import usd_pkg::*;

   // Bound register for the above_bound flag.
   logic [CP_WIDTH-1:0] max_cp_ff;

   // Input register.
   logic                in_valid_ff, in_valid_in;
   logic                in_restart_ff;
   logic [7:0]          in_byte_ff;

   // Decoder state, updated when a beat moves into the result register.
   usd_state_type       state_ff, state_in;

   // Result register.
   logic                out_valid_ff, out_valid_in;
   usd_result_type      out_ff, out_in;

   logic                out_ready;
   logic                advance;
   logic                take;

   // The result register can load when it is empty or being emptied this cycle.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = out_ready ? advance : out_valid_ff;
   end

   usd_step_logic u_step (
      .state_cur      (state_ff),
      .restart        (in_restart_ff),
      .in_byte        (in_byte_ff),
      .max_code_point (max_cp_ff),
      .state_nxt      (state_in),
      .result         (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         max_cp_ff    <= MAX_CP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            max_cp_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         in_restart_ff <= req_restart;
         in_byte_ff    <= req_in_byte;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_accepted    = out_ff.accepted;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_seq_length  = out_ff.seq_length;
   assign rsp_overlong    = out_ff.overlong;
   assign rsp_above_bound = out_ff.above_bound;

endmodule
